/* rtl/motor_command_safety_gate_top_macros.svh */
// Assertion macros for the motor command safety gate.
// Used by motor_command_safety_gate_top; expects clk and rst in scope.
`ifndef MOTOR_COMMAND_SAFETY_GATE_TOP_MACROS_SVH
`define MOTOR_COMMAND_SAFETY_GATE_TOP_MACROS_SVH

// Condition must hold at every edge outside reset.
`define MCSG_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define MCSG_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MCSG_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/mcsg_pkg.sv */
// Package for the motor command safety gate: event codes, register indexes,
// item type, duty scaling constants and the request clamp. No dependencies.
package mcsg_pkg;

  localparam int CMD_W    = 3;
  localparam int SEQ_W    = 32;
  localparam int REQ_W    = 32;
  localparam int DRV_W    = 11;  // signed, -1000..1000
  localparam int MAG_W    = 10;  // |drive| <= 1000
  localparam int AGE_W    = 16;
  localparam int TICK_W   = 32;
  localparam int DUTY_W   = 8;
  localparam int PWM_W    = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Event codes
  localparam logic [CMD_W-1:0] EV_COMMAND    = 3'd0;
  localparam logic [CMD_W-1:0] EV_TICK       = 3'd1;
  localparam logic [CMD_W-1:0] EV_LEFT_EDGE  = 3'd2;
  localparam logic [CMD_W-1:0] EV_RIGHT_EDGE = 3'd3;
  localparam logic [CMD_W-1:0] EV_CONNECT    = 3'd4;
  localparam logic [CMD_W-1:0] EV_DISCONNECT = 3'd5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_SCALE = 4'd1;

  localparam logic [AGE_W-1:0] TIMEOUT_RESET = 16'd300;
  localparam logic [AGE_W-1:0] AGE_MAX       = 16'hFFFF;

  localparam logic signed [DRV_W-1:0] DRV_LIMIT_POS = 11'sd1000;
  localparam logic signed [DRV_W-1:0] DRV_LIMIT_NEG = -11'sd1000;

  // x / 1000 for x < 2^18 equals (x * RECIP_1000) >> RECIP_SHIFT exactly.
  // The pwm register is kept pre-multiplied by RECIP_1000.
  localparam int RECIP_1000  = 268436;
  localparam int RECIP_SHIFT = 28;
  localparam int SCALE_W     = 27;
  localparam int PROD_W      = MAG_W + SCALE_W;
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(255 * RECIP_1000);
  localparam logic [SCALE_W-1:0] RECIP_K     = SCALE_W'(RECIP_1000);

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [SEQ_W-1:0]        sequence_req;
    logic signed [REQ_W-1:0] left_request;
    logic signed [REQ_W-1:0] right_request;
    logic                    encoder_b_high;
    logic                    estop_low;
    logic                    left_bumper_low;
    logic                    right_bumper_low;
  } item_t;

  function automatic logic signed [DRV_W-1:0] clamp_req(input logic signed [REQ_W-1:0] v);
    logic signed [DRV_W-1:0] r;
    if (v > REQ_W'(DRV_LIMIT_POS)) begin
      r = DRV_LIMIT_POS;
    end else if (v < REQ_W'(DRV_LIMIT_NEG)) begin
      r = DRV_LIMIT_NEG;
    end else begin
      r = v[DRV_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/motor_command_safety_gate_top.sv */
// Motor command safety gate: sequence check, clamp, command aging, e-stop
// latch, bumper gating, duty scaling and encoder counting.
// Depends on mcsg_pkg and motor_command_safety_gate_top_macros.svh.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------
//   in      | into      | in_valid / in_stall  | cmd, sequence_req, requests, pins
//   out     | out of    | out_valid / out_stall| duties, reverse bits, status, counts
//   cfg     | into      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One event per cycle sustained while out_stall stays low. An event is held in
// the input register, is evaluated against the state in one pass (clamp, age
// update, stop decision, one 10x27 multiply per side for the duty) and lands in
// the result register, which raises out_valid.
// rst is synchronous: clears state, valids, and restores timeout 300 and
// full scale 255. cfg_ready is always high.
// out_stall holds the result register; the input register then holds too,
// and in_stall rises only while the input register is occupied.
`include "motor_command_safety_gate_top_macros.svh"

module motor_command_safety_gate_top (
  input  logic                                     clk,
  input  logic                                     rst,
  // input channel
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic [mcsg_pkg::CMD_W-1:0]               cmd,
  input  logic [mcsg_pkg::SEQ_W-1:0]               sequence_req,
  input  logic signed [mcsg_pkg::REQ_W-1:0]        left_request,
  input  logic signed [mcsg_pkg::REQ_W-1:0]        right_request,
  input  logic                                     encoder_b_high,
  input  logic                                     estop_low,
  input  logic                                     left_bumper_low,
  input  logic                                     right_bumper_low,
  // result channel
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [mcsg_pkg::DUTY_W-1:0]              left_duty,
  output logic                                     left_reverse,
  output logic [mcsg_pkg::DUTY_W-1:0]              right_duty,
  output logic                                     right_reverse,
  output logic                                     drive_stopped,
  output logic                                     estop_latched,
  output logic [mcsg_pkg::SEQ_W-1:0]               last_sequence,
  output logic signed [mcsg_pkg::TICK_W-1:0]       left_count,
  output logic signed [mcsg_pkg::TICK_W-1:0]       right_count,
  output logic [mcsg_pkg::AGE_W-1:0]               command_age,
  // configuration
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [mcsg_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [mcsg_pkg::CFG_DATA_W-1:0]          cfg_data
);

  // ---------------------------------------------------------------- config
  logic [mcsg_pkg::AGE_W-1:0]   timeout;
  logic [mcsg_pkg::SCALE_W-1:0] duty_scale;  // pwm_full_scale * RECIP_1000

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout    <= mcsg_pkg::TIMEOUT_RESET;
      duty_scale <= mcsg_pkg::SCALE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mcsg_pkg::CFG_TIMEOUT: begin
          timeout <= cfg_data;
        end
        mcsg_pkg::CFG_PWM_SCALE: begin
          duty_scale <= mcsg_pkg::SCALE_W'(cfg_data[mcsg_pkg::PWM_W-1:0]) * mcsg_pkg::RECIP_K;
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------- flow control
  mcsg_pkg::item_t item;
  logic            item_valid;
  logic            out_free;
  logic            step;
  logic            in_xfer;

  assign out_free = !out_valid || !out_stall;
  assign step     = item_valid && out_free;
  assign in_stall = item_valid && !out_free;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_xfer) begin
      item_valid <= 1'b1;
    end else if (step) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item.cmd              <= cmd;
      item.sequence_req     <= sequence_req;
      item.left_request     <= left_request;
      item.right_request    <= right_request;
      item.encoder_b_high   <= encoder_b_high;
      item.estop_low        <= estop_low;
      item.left_bumper_low  <= left_bumper_low;
      item.right_bumper_low <= right_bumper_low;
    end
  end

  // ------------------------------------------------------------------ state
  logic [mcsg_pkg::SEQ_W-1:0]         accepted_sequence, accepted_sequence_next;
  logic signed [mcsg_pkg::DRV_W-1:0]  left_drive, left_drive_next;
  logic signed [mcsg_pkg::DRV_W-1:0]  right_drive, right_drive_next;
  logic [mcsg_pkg::AGE_W-1:0]         age_counter, age_counter_next;
  logic                               stop_latch, stop_latch_next;
  logic [mcsg_pkg::TICK_W-1:0]        left_ticks, left_ticks_next;
  logic [mcsg_pkg::TICK_W-1:0]        right_ticks, right_ticks_next;

  logic [mcsg_pkg::TICK_W-1:0]        tick_delta;
  logic                               stopped;
  logic signed [mcsg_pkg::DRV_W-1:0]  cand_left, cand_right;
  logic signed [mcsg_pkg::DRV_W-1:0]  safe_left, safe_right;
  logic [mcsg_pkg::DRV_W-1:0]         abs_left, abs_right;
  logic [mcsg_pkg::PROD_W-1:0]        prod_left, prod_right;
  logic [mcsg_pkg::DUTY_W-1:0]        duty_left, duty_right;
  logic                               rev_left, rev_right;

  // encoder B high counts up, low counts down
  assign tick_delta = item.encoder_b_high ? mcsg_pkg::TICK_W'(1) : '1;

  always_comb begin
    accepted_sequence_next = accepted_sequence;
    cand_left              = left_drive;
    cand_right             = right_drive;
    age_counter_next       = age_counter;
    left_ticks_next        = left_ticks;
    right_ticks_next       = right_ticks;
    stopped                = 1'b0;

    unique case (item.cmd)
      mcsg_pkg::EV_COMMAND: begin
        // equal sequence is accepted, older is dropped
        if (item.sequence_req >= accepted_sequence) begin
          accepted_sequence_next = item.sequence_req;
          cand_left              = mcsg_pkg::clamp_req(item.left_request);
          cand_right             = mcsg_pkg::clamp_req(item.right_request);
          age_counter_next       = '0;
        end
      end
      mcsg_pkg::EV_TICK: begin
        if (age_counter != mcsg_pkg::AGE_MAX) begin
          age_counter_next = age_counter + mcsg_pkg::AGE_W'(1);
        end
      end
      mcsg_pkg::EV_LEFT_EDGE: begin
        left_ticks_next = left_ticks + tick_delta;
      end
      mcsg_pkg::EV_RIGHT_EDGE: begin
        right_ticks_next = right_ticks + tick_delta;
      end
      mcsg_pkg::EV_CONNECT: begin
        age_counter_next = '0;
      end
      mcsg_pkg::EV_DISCONNECT: begin
        stopped = 1'b1;
      end
      default: begin
      end
    endcase

    stop_latch_next = stop_latch || item.estop_low;
    if (stop_latch_next || (age_counter_next > timeout)) begin
      stopped = 1'b1;
    end

    left_drive_next  = stopped ? '0 : cand_left;
    right_drive_next = stopped ? '0 : cand_right;

    // bumper blocks forward drive on its side, output only
    safe_left  = (item.left_bumper_low && (left_drive_next > 0)) ? '0 : left_drive_next;
    safe_right = (item.right_bumper_low && (right_drive_next > 0)) ? '0 : right_drive_next;

    rev_left  = safe_left < 0;
    rev_right = safe_right < 0;
    abs_left  = rev_left ? mcsg_pkg::DRV_W'(-safe_left) : mcsg_pkg::DRV_W'(safe_left);
    abs_right = rev_right ? mcsg_pkg::DRV_W'(-safe_right) : mcsg_pkg::DRV_W'(safe_right);

    // |cmd| * pwm / 1000 via the pre-scaled reciprocal
    prod_left  = mcsg_pkg::PROD_W'(abs_left[mcsg_pkg::MAG_W-1:0]) *
                 mcsg_pkg::PROD_W'(duty_scale);
    prod_right = mcsg_pkg::PROD_W'(abs_right[mcsg_pkg::MAG_W-1:0]) *
                 mcsg_pkg::PROD_W'(duty_scale);
    duty_left  = prod_left[mcsg_pkg::RECIP_SHIFT +: mcsg_pkg::DUTY_W];
    duty_right = prod_right[mcsg_pkg::RECIP_SHIFT +: mcsg_pkg::DUTY_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_sequence <= '0;
      left_drive        <= '0;
      right_drive       <= '0;
      age_counter       <= '0;
      stop_latch        <= 1'b0;
      left_ticks        <= '0;
      right_ticks       <= '0;
    end else if (step) begin
      accepted_sequence <= accepted_sequence_next;
      left_drive        <= left_drive_next;
      right_drive       <= right_drive_next;
      age_counter       <= age_counter_next;
      stop_latch        <= stop_latch_next;
      left_ticks        <= left_ticks_next;
      right_ticks       <= right_ticks_next;
    end
  end

  // --------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      left_duty     <= duty_left;
      left_reverse  <= rev_left;
      right_duty    <= duty_right;
      right_reverse <= rev_right;
      drive_stopped <= stopped;
      estop_latched <= stop_latch_next;
      last_sequence <= accepted_sequence_next;
      left_count    <= left_ticks_next;
      right_count   <= right_ticks_next;
      command_age   <= age_counter_next;
    end
  end

  // -------------------------------------------------------------- checks
  logic out_idle;
  logic drive_zero;
  logic drive_in_range;

  assign out_idle       = (left_duty == '0) && (right_duty == '0) &&
                          !left_reverse && !right_reverse;
  assign drive_zero     = (left_drive == '0) && (right_drive == '0);
  assign drive_in_range = (left_drive <= mcsg_pkg::DRV_LIMIT_POS) &&
                          (left_drive >= mcsg_pkg::DRV_LIMIT_NEG) &&
                          (right_drive <= mcsg_pkg::DRV_LIMIT_POS) &&
                          (right_drive >= mcsg_pkg::DRV_LIMIT_NEG);

  `MCSG_ASSERT_NEXT(a_latch_sticky, stop_latch, stop_latch, "stop latch released without reset")
  `MCSG_ASSERT_IMPL(a_stop_zero_duty, out_valid && drive_stopped, out_idle, "duty while stopped")
  `MCSG_ASSERT_IMPL(a_latch_stops, out_valid && estop_latched, drive_stopped, "latch without stop")
  `MCSG_ASSERT_NEXT(a_stop_clears_drive, step && stopped, drive_zero, "drive kept after stop")
  `MCSG_ASSERT(a_drive_range, drive_in_range, "stored drive out of range")

endmodule

/* bench/motor_command_safety_gate_top_tb.sv */
// Self-checking bench for motor_command_safety_gate_top: directed and random event traffic,
// with a transaction-level predictor of the gate state checked against every result transfer.
// Depends on mcsg_pkg and the RTL of motor_command_safety_gate_top.
module motor_command_safety_gate_top_tb;

  // Codes 6 and 7 carry no event; the gate must still evaluate its safety logic.
  localparam logic [mcsg_pkg::CMD_W-1:0] EV_RESERVED_6 = 3'd6;
  localparam logic [mcsg_pkg::CMD_W-1:0] EV_RESERVED_7 = 3'd7;

  localparam int CMD_LIMIT      = 1000;  // clamp bound and full-scale command
  localparam int RESULT_LATENCY = 2;     // transfer in to result transfer
  localparam int QUIET_LIMIT    = 1000;  // cycles without any transfer before giving up
  localparam int MAX_REPORTS    = 100;   // keep the log readable on a badly broken build

  typedef struct packed {
    logic [mcsg_pkg::DUTY_W-1:0] left_duty;
    logic                        left_reverse;
    logic [mcsg_pkg::DUTY_W-1:0] right_duty;
    logic                        right_reverse;
    logic                        drive_stopped;
    logic                        estop_latched;
    logic [mcsg_pkg::SEQ_W-1:0]  last_sequence;
    logic [mcsg_pkg::TICK_W-1:0] left_count;
    logic [mcsg_pkg::TICK_W-1:0] right_count;
    logic [mcsg_pkg::AGE_W-1:0]  command_age;
  } gate_status_t;

  logic clk;
  logic rst;

  logic                               in_valid;
  logic                               in_stall;
  logic [mcsg_pkg::CMD_W-1:0]         cmd;
  logic [mcsg_pkg::SEQ_W-1:0]         sequence_req;
  logic signed [mcsg_pkg::REQ_W-1:0]  left_request;
  logic signed [mcsg_pkg::REQ_W-1:0]  right_request;
  logic                               encoder_b_high;
  logic                               estop_low;
  logic                               left_bumper_low;
  logic                               right_bumper_low;

  logic                               out_valid;
  logic                               out_stall;
  logic [mcsg_pkg::DUTY_W-1:0]        left_duty;
  logic                               left_reverse;
  logic [mcsg_pkg::DUTY_W-1:0]        right_duty;
  logic                               right_reverse;
  logic                               drive_stopped;
  logic                               estop_latched;
  logic [mcsg_pkg::SEQ_W-1:0]         last_sequence;
  logic signed [mcsg_pkg::TICK_W-1:0] left_count;
  logic signed [mcsg_pkg::TICK_W-1:0] right_count;
  logic [mcsg_pkg::AGE_W-1:0]         command_age;

  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [mcsg_pkg::CFG_IDX_W-1:0]     cfg_index;
  logic [mcsg_pkg::CFG_DATA_W-1:0]    cfg_data;

  motor_command_safety_gate_top DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .cmd              (cmd),
    .sequence_req     (sequence_req),
    .left_request     (left_request),
    .right_request    (right_request),
    .encoder_b_high   (encoder_b_high),
    .estop_low        (estop_low),
    .left_bumper_low  (left_bumper_low),
    .right_bumper_low (right_bumper_low),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .left_duty        (left_duty),
    .left_reverse     (left_reverse),
    .right_duty       (right_duty),
    .right_reverse    (right_reverse),
    .drive_stopped    (drive_stopped),
    .estop_latched    (estop_latched),
    .last_sequence    (last_sequence),
    .left_count       (left_count),
    .right_count      (right_count),
    .command_age      (command_age),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a mirror of the gate, advanced once per accepted input
  // transfer. Register values start at their reset defaults.
  // ---------------------------------------------------------------------------
  logic [mcsg_pkg::SEQ_W-1:0]        seq_accepted    = '0;
  logic signed [mcsg_pkg::DRV_W-1:0] left_cmd        = '0;
  logic signed [mcsg_pkg::DRV_W-1:0] right_cmd       = '0;
  logic [mcsg_pkg::AGE_W-1:0]        age_ticks       = '0;
  logic                              estop_seen      = 1'b0;
  logic [mcsg_pkg::TICK_W-1:0]       left_pos        = '0;
  logic [mcsg_pkg::TICK_W-1:0]       right_pos       = '0;
  logic [mcsg_pkg::AGE_W-1:0]        timeout_setting = 16'd300;
  logic [mcsg_pkg::PWM_W-1:0]        pwm_setting     = 8'd255;

  gate_status_t expected_status[$];  // oldest first
  int           failures = 0;
  bit           idle_on  = 1'b0;     // random gaps on input and random output stalls

  function automatic logic signed [mcsg_pkg::DRV_W-1:0] limit_request(
      input logic signed [mcsg_pkg::REQ_W-1:0] r);
    if (r > CMD_LIMIT) return mcsg_pkg::DRV_W'(CMD_LIMIT);
    if (r < -CMD_LIMIT) return mcsg_pkg::DRV_W'(-CMD_LIMIT);
    return r[mcsg_pkg::DRV_W-1:0];
  endfunction

  // duty = |c| * full_scale / 1000, truncated; reverse flags a negative command
  function automatic void scale_drive(input logic signed [mcsg_pkg::DRV_W-1:0] c,
                                      output logic [mcsg_pkg::DUTY_W-1:0] duty,
                                      output logic rev);
    int mag;
    mag  = (c < 0) ? -int'(c) : int'(c);
    duty = mcsg_pkg::DUTY_W'((mag * int'(pwm_setting)) / CMD_LIMIT);
    rev  = (c < 0);
  endfunction

  function automatic gate_status_t predict_gate(input mcsg_pkg::item_t ev);
    gate_status_t                      r;
    logic                              stop;
    logic signed [mcsg_pkg::DRV_W-1:0] safe_left;
    logic signed [mcsg_pkg::DRV_W-1:0] safe_right;
    r    = '0;
    stop = 1'b0;
    case (ev.cmd)
      mcsg_pkg::EV_COMMAND: begin
        // equal sequence still counts as fresh
        if (ev.sequence_req >= seq_accepted) begin
          seq_accepted = ev.sequence_req;
          left_cmd     = limit_request(ev.left_request);
          right_cmd    = limit_request(ev.right_request);
          age_ticks    = '0;
        end
      end
      mcsg_pkg::EV_TICK: begin
        if (age_ticks != mcsg_pkg::AGE_MAX) age_ticks = age_ticks + 16'd1;
      end
      mcsg_pkg::EV_LEFT_EDGE:
        left_pos  = left_pos  + (ev.encoder_b_high ? 32'd1 : 32'hFFFF_FFFF);
      mcsg_pkg::EV_RIGHT_EDGE:
        right_pos = right_pos + (ev.encoder_b_high ? 32'd1 : 32'hFFFF_FFFF);
      mcsg_pkg::EV_CONNECT:    age_ticks = '0;
      mcsg_pkg::EV_DISCONNECT: stop = 1'b1;
      default: ;
    endcase

    if (ev.estop_low) estop_seen = 1'b1;
    if (estop_seen || ev.estop_low || age_ticks > timeout_setting) stop = 1'b1;

    if (stop) begin
      left_cmd  = '0;
      right_cmd = '0;
    end else begin
      // a pressed bumper only masks forward drive, the stored command survives
      safe_left  = (ev.left_bumper_low && left_cmd > 0) ? 11'sd0 : left_cmd;
      safe_right = (ev.right_bumper_low && right_cmd > 0) ? 11'sd0 : right_cmd;
      scale_drive(safe_left, r.left_duty, r.left_reverse);
      scale_drive(safe_right, r.right_duty, r.right_reverse);
    end
    r.drive_stopped = stop;
    r.estop_latched = estop_seen;
    r.last_sequence = seq_accepted;
    r.left_count    = left_pos;
    r.right_count   = right_pos;
    r.command_age   = age_ticks;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, and the scoreboard.
  // out_stall is read before its update, i.e. the value the gate saw this edge.
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      failures++;
      if (failures <= MAX_REPORTS) $error("%s: expected %0h, got %0h", field, want, got);
    end
  endtask

  always @(posedge clk) begin
    gate_status_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_status.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS) $error("result transfer with nothing expected");
      end else begin
        want = expected_status.pop_front();
        compare_field("left_duty",     32'(want.left_duty),     32'(left_duty));
        compare_field("left_reverse",  32'(want.left_reverse),  32'(left_reverse));
        compare_field("right_duty",    32'(want.right_duty),    32'(right_duty));
        compare_field("right_reverse", 32'(want.right_reverse), 32'(right_reverse));
        compare_field("drive_stopped", 32'(want.drive_stopped), 32'(drive_stopped));
        compare_field("estop_latched", 32'(want.estop_latched), 32'(estop_latched));
        compare_field("last_sequence", want.last_sequence,      last_sequence);
        compare_field("left_count",    want.left_count,         left_count);
        compare_field("right_count",   want.right_count,        right_count);
        compare_field("command_age",   32'(want.command_age),   32'(command_age));
      end
    end

    if (rst || !idle_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // Watchdog: any transfer on any channel restarts the count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("** motor_command_safety_gate_top: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Every task returns at a rising edge with no pending
  // assignment to in_valid, so the next transfer can keep valid high.
  // ---------------------------------------------------------------------------

  // One input transfer; the expectation is queued at the accepting edge.
  task automatic send_event(input mcsg_pkg::item_t ev);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    cmd              <= ev.cmd;
    sequence_req     <= ev.sequence_req;
    left_request     <= ev.left_request;
    right_request    <= ev.right_request;
    encoder_b_high   <= ev.encoder_b_high;
    estop_low        <= ev.estop_low;
    left_bumper_low  <= ev.left_bumper_low;
    right_bumper_low <= ev.right_bumper_low;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_status.push_back(predict_gate(ev));
  endtask

  // Stop sending and let every outstanding result come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  // Registers change only with the pipe empty.
  task automatic configure(input logic [mcsg_pkg::AGE_W-1:0] timeout_val,
                           input logic [mcsg_pkg::PWM_W-1:0] pwm_val);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= mcsg_pkg::CFG_TIMEOUT;
    cfg_data  <= timeout_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    timeout_setting = timeout_val;
    cfg_index <= mcsg_pkg::CFG_PWM_SCALE;
    cfg_data  <= mcsg_pkg::CFG_DATA_W'(pwm_val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pwm_setting = pwm_val;
    cfg_valid <= 1'b0;
  endtask

  // Unused payload fields carry random noise.
  function automatic mcsg_pkg::item_t plain_event(input logic [mcsg_pkg::CMD_W-1:0] code,
                                                  input logic b_level);
    mcsg_pkg::item_t ev;
    ev                = '0;
    ev.cmd            = code;
    ev.sequence_req   = $urandom;
    ev.left_request   = $urandom;
    ev.right_request  = $urandom;
    ev.encoder_b_high = b_level;
    return ev;
  endfunction

  function automatic mcsg_pkg::item_t command_event(
      input logic [mcsg_pkg::SEQ_W-1:0] seq,
      input logic signed [mcsg_pkg::REQ_W-1:0] l,
      input logic signed [mcsg_pkg::REQ_W-1:0] r);
    mcsg_pkg::item_t ev;
    ev               = plain_event(mcsg_pkg::EV_COMMAND, 1'($urandom_range(0, 1)));
    ev.sequence_req  = seq;
    ev.left_request  = l;
    ev.right_request = r;
    return ev;
  endfunction

  function automatic logic signed [mcsg_pkg::REQ_W-1:0] random_request();
    case ($urandom_range(0, 9))
      0: return $urandom;                                              // anywhere in range
      1: return ($urandom_range(0, 1) ? 1 : -1) * (1001 + int'($urandom_range(0, 5000)));
      2: return $urandom_range(0, 1) ? CMD_LIMIT : -CMD_LIMIT;
      default: return int'($urandom_range(0, 2 * CMD_LIMIT)) - CMD_LIMIT;
    endcase
  endfunction

  // Mostly commands that are fresh or repeat the last sequence, so the drive
  // actually runs; some stale ones and a few arbitrary jumps.
  function automatic mcsg_pkg::item_t random_event(input bit with_estop);
    mcsg_pkg::item_t ev;
    int              pick;
    ev   = plain_event(mcsg_pkg::EV_TICK, 1'($urandom_range(0, 1)));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      ev.cmd           = mcsg_pkg::EV_COMMAND;
      ev.left_request  = random_request();
      ev.right_request = random_request();
      pick = $urandom_range(0, 99);
      if (pick < 75)
        ev.sequence_req = (seq_accepted > 32'hFFFF_FFF0) ? seq_accepted
                                                         : seq_accepted + $urandom_range(0, 3);
      else if (pick < 95 && seq_accepted != 0)
        ev.sequence_req = $urandom_range(0, seq_accepted - 1);
      else
        ev.sequence_req = $urandom;
    end else if (pick < 60) ev.cmd = mcsg_pkg::EV_TICK;
    else if (pick < 72)     ev.cmd = mcsg_pkg::EV_LEFT_EDGE;
    else if (pick < 84)     ev.cmd = mcsg_pkg::EV_RIGHT_EDGE;
    else if (pick < 91)     ev.cmd = mcsg_pkg::EV_CONNECT;
    else if (pick < 96)     ev.cmd = mcsg_pkg::EV_DISCONNECT;
    else                    ev.cmd = $urandom_range(0, 1) ? EV_RESERVED_6 : EV_RESERVED_7;
    ev.left_bumper_low  = ($urandom_range(0, 3) == 0);
    ev.right_bumper_low = ($urandom_range(0, 3) == 0);
    ev.estop_low        = with_estop && ($urandom_range(0, 3) == 0);
    return ev;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers (300 ticks, full scale 255). Sequence 0 equals the reset
  // value and must be taken; a lower sequence is dropped; clamp at both ends.
  task automatic test_command_clamp_and_order();
    send_event(command_event(32'd0, 32'sd1000, -32'sd1000));
    send_event(command_event(32'd5, 32'sh7FFF_FFFF, 32'sh8000_0000));
    send_event(command_event(32'd5, 32'sd1001, -32'sd1001));
    send_event(command_event(32'd4, 32'sd7, 32'sd7));
    send_event(command_event(32'd6, 32'sd1, -32'sd1));     // rounds to zero duty
    send_event(command_event(32'd7, 32'sd0, -32'sd999));
  endtask

  // Bumpers mask forward drive only.
  task automatic test_bumper_gating();
    mcsg_pkg::item_t ev;
    ev = command_event(32'd8, 32'sd500, -32'sd500);
    ev.left_bumper_low  = 1'b1;
    ev.right_bumper_low = 1'b1;
    send_event(ev);
    ev = command_event(32'd8, -32'sd700, 32'sd700);
    ev.left_bumper_low  = 1'b1;
    ev.right_bumper_low = 1'b1;
    send_event(ev);
  endtask

  // Counting down from zero wraps to all ones.
  task automatic test_encoder_counts();
    send_event(plain_event(mcsg_pkg::EV_LEFT_EDGE, 1'b0));
    send_event(plain_event(mcsg_pkg::EV_LEFT_EDGE, 1'b1));
    send_event(plain_event(mcsg_pkg::EV_RIGHT_EDGE, 1'b0));
    send_event(plain_event(mcsg_pkg::EV_RIGHT_EDGE, 1'b1));
  endtask

  task automatic test_reserved_codes();
    send_event(plain_event(EV_RESERVED_6, 1'b1));
    send_event(plain_event(EV_RESERVED_7, 1'b0));
  endtask

  // Timeout 1: age 1 still runs, age 2 stops and clears the stored commands;
  // connect restarts the age but leaves the drive at zero until a new command.
  task automatic test_timeout_stop();
    configure(16'd1, 8'd1);
    send_event(command_event(32'd9, 32'sd1000, 32'sd0));
    send_event(plain_event(mcsg_pkg::EV_TICK, 1'b0));
    send_event(plain_event(mcsg_pkg::EV_TICK, 1'b0));
    send_event(plain_event(mcsg_pkg::EV_CONNECT, 1'b0));
    send_event(command_event(32'd10, -32'sd1000, 32'sd1000));
  endtask

  // Disconnect stops for one event; the next command runs again.
  task automatic test_disconnect();
    configure(mcsg_pkg::TIMEOUT_RESET, 8'd255);
    send_event(plain_event(mcsg_pkg::EV_DISCONNECT, 1'b1));
    send_event(command_event(32'd11, 32'sd800, 32'sd300));
  endtask

  // Zero full scale gives zero duty; zero timeout trips on the first tick.
  task automatic test_zero_settings();
    configure(16'd0, 8'd0);
    send_event(command_event(32'd12, 32'sd1000, -32'sd1000));
    send_event(plain_event(mcsg_pkg::EV_TICK, 1'b1));
  endtask

  // Largest timeout: a run of ticks keeps the drive running.
  task automatic test_large_timeout();
    configure(16'hFFFF, 8'd255);
    send_event(command_event(32'd13, 32'sd1000, -32'sd1000));
    repeat (20) send_event(plain_event(mcsg_pkg::EV_TICK, 1'($urandom_range(0, 1))));
  endtask

  task automatic test_random_traffic(input logic [mcsg_pkg::AGE_W-1:0] timeout_val,
                                     input logic [mcsg_pkg::PWM_W-1:0] pwm_val,
                                     input int count);
    configure(timeout_val, pwm_val);
    repeat (count) send_event(random_event(1'b0));
  endtask

  // Last, since only reset clears the latch: once set, every event stops the
  // drive, even with the pin released and a fresh command.
  task automatic test_estop_latch();
    mcsg_pkg::item_t ev;
    send_event(command_event(seq_accepted, 32'sd900, -32'sd900));
    ev = plain_event(mcsg_pkg::EV_TICK, 1'b0);
    ev.estop_low = 1'b1;
    send_event(ev);
    send_event(command_event(seq_accepted, 32'sd900, -32'sd900));
    repeat (40) send_event(random_event(1'b1));
  endtask

  initial begin : stimulus
    rst              <= 1'b1;
    in_valid         <= 1'b0;
    cmd              <= mcsg_pkg::EV_COMMAND;
    sequence_req     <= '0;
    left_request     <= '0;
    right_request    <= '0;
    encoder_b_high   <= 1'b0;
    estop_low        <= 1'b0;
    left_bumper_low  <= 1'b0;
    right_bumper_low <= 1'b0;
    cfg_valid        <= 1'b0;
    cfg_index        <= mcsg_pkg::CFG_TIMEOUT;
    cfg_data         <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;

    test_command_clamp_and_order();
    test_bumper_gating();
    test_encoder_counts();
    test_reserved_codes();
    test_timeout_stop();
    test_disconnect();
    test_zero_settings();
    test_large_timeout();

    test_random_traffic(mcsg_pkg::TIMEOUT_RESET, 8'd255, 200);
    test_random_traffic(16'd2, 8'd200, 200);
    test_random_traffic(16'hFFFF, 8'd1, 120);
    test_random_traffic(16'd1, 8'd255, 120);
    test_random_traffic(mcsg_pkg::AGE_W'($urandom_range(0, 8)),
                        mcsg_pkg::PWM_W'($urandom_range(0, 255)), 100);

    // closing stretch runs back to back with no gaps or stalls
    idle_on = 1'b0;
    test_random_traffic(16'd4, 8'd128, 100);
    test_estop_latch();

    drain_results();
    if (failures == 0) begin
      $display("** motor_command_safety_gate_top: PASSED **");
    end else begin
      $display("** motor_command_safety_gate_top: FAILED **");
    end
    $finish;
  end

endmodule
